@@ rtl/fblw_pkg.sv @@
// ----------------------------------------------------------------------------
// fblw_pkg
// Shared constants for the paged monochrome frame line and bit writer.
// ----------------------------------------------------------------------------
package fblw_pkg;

   localparam int COLUMNS    = 128;
   localparam int PAGES      = 8;
   localparam int PAGE_BITS  = 8;
   localparam int ROWS       = PAGES * PAGE_BITS;
   localparam int STORE_SIZE = PAGES * COLUMNS;
   localparam int ADDR_W     = $clog2(STORE_SIZE);
   localparam int MAX_BITS   = 8;

   localparam logic [2:0] ACT_CLEAR = 3'd0;
   localparam logic [2:0] ACT_PIXEL = 3'd1;
   localparam logic [2:0] ACT_LINE  = 3'd2;
   localparam logic [2:0] ACT_FIELD = 3'd3;
   localparam logic [2:0] ACT_READ  = 3'd4;

   localparam logic [2:0] K_PLOT  = 3'd0;
   localparam logic [2:0] K_VERT  = 3'd1;
   localparam logic [2:0] K_HORZ  = 3'd2;
   localparam logic [2:0] K_DIAGX = 3'd3;
   localparam logic [2:0] K_DIAGY = 3'd4;
   localparam logic [2:0] K_FIELD = 3'd5;
   localparam logic [2:0] K_READ  = 3'd6;

endpackage

@@ rtl/framebuffer_line_and_bit_writer_unit.sv @@
// ----------------------------------------------------------------------------
// framebuffer_line_and_bit_writer_unit
// Paged monochrome frame store with pixel, line, bit field, clear and read
// commands; pixel, line and bit field run through one read-modify-write path.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                Fields
//  request   start, busy              req_action, req_x_coord, req_y_coord,
//                                     req_x_end, req_y_end, req_bits_value,
//                                     req_bit_count
//  response  rsp_valid (one cycle)    rsp_read_data
//
//  Each stored pixel is a read of the single frame memory followed by a write
//  of the merged byte; a line does this for each of its pixels and a bit field
//  for each of the two pages it may cover. A clear walks the whole memory, one
//  byte a cycle, STORE_SIZE bytes (1024 at 128x64). After reset the same
//  clearing pass runs with busy high and no response. The response strobe
//  comes in the cycle after the last step, and busy is low in that cycle.
//  Responses cannot be stalled.
// ----------------------------------------------------------------------------
module framebuffer_line_and_bit_writer_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [2:0] req_action,
   input  logic [7:0] req_x_coord,
   input  logic [7:0] req_y_coord,
   input  logic [7:0] req_x_end,
   input  logic [7:0] req_y_end,
   input  logic [7:0] req_bits_value,
   input  logic [3:0] req_bit_count,
   output logic       rsp_valid,
   output logic [7:0] rsp_read_data
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CLR  = 3'd1;
   localparam logic [2:0] S_RD   = 3'd2;
   localparam logic [2:0] S_WR   = 3'd3;
   localparam logic [2:0] S_RDB  = 3'd4;
   localparam logic [2:0] S_RDO  = 3'd5;

   localparam int AW    = fblw_pkg::ADDR_W;
   localparam int EPS_W = 11;

   logic [7:0] mem [fblw_pkg::STORE_SIZE];

   logic [2:0]              state_ff, state_in;
   logic [2:0]              kind_ff, kind_in;
   logic [7:0]              cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [7:0]              end_x_ff, end_x_in, end_y_ff, end_y_in;
   logic [7:0]              dx_ff, dx_in, dy_ff, dy_in;
   logic                    ux_neg_ff, ux_neg_in, uy_neg_ff, uy_neg_in;
   logic signed [EPS_W-1:0] eps_ff, eps_in;
   logic [15:0]             wdata_ff, wdata_in, wmask_ff, wmask_in;
   logic                    phase_ff, phase_in;
   logic [AW-1:0]           clr_cnt_ff, clr_cnt_in;
   logic                    clr_rsp_ff, clr_rsp_in;
   logic [AW-1:0]           addr_ff, addr_in;
   logic [7:0]              data_ff, data_in, mask_ff, mask_in;
   logic                    wen_ff, wen_in;
   logic                    rd_ok_ff, rd_ok_in;
   logic [7:0]              mem_q_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [7:0]              rsp_data_ff, rsp_data_in;

   logic                    mem_we;
   logic [AW-1:0]           mem_waddr;
   logic [7:0]              mem_wdata;

   logic [7:0]              tgt_page;
   logic [5:0]              field_page;
   logic [15:0]             tgt_lin;
   logic [AW-1:0]           tgt_addr;
   logic [7:0]              tgt_mask, tgt_data;
   logic                    tgt_ok, col_ok;

   logic [7:0]              x_step, y_step, step_minor, step_major;
   logic signed [EPS_W-1:0] eps_add;
   logic signed [EPS_W:0]   eps_dbl;
   logic                    take;

   logic [3:0]              fld_len;
   logic [7:0]              fld_bits;

   assign busy          = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

   always_comb begin
      col_ok     = ({1'b0, cur_x_ff} < 9'(fblw_pkg::COLUMNS));
      field_page = {1'b0, cur_y_ff[7:3]} + {5'd0, phase_ff};
      tgt_page   = {3'd0, cur_y_ff[7:3]};
      tgt_mask   = 8'd1 << cur_y_ff[2:0];
      tgt_data   = tgt_mask;
      tgt_ok     = col_ok && ({1'b0, cur_y_ff} < 9'(fblw_pkg::ROWS));
      case (kind_ff)
         fblw_pkg::K_FIELD: begin
            tgt_page = {2'd0, field_page};
            tgt_mask = phase_ff ? wmask_ff[15:8] : wmask_ff[7:0];
            tgt_data = phase_ff ? wdata_ff[15:8] : wdata_ff[7:0];
            tgt_ok   = col_ok && ({3'd0, field_page} < 9'(fblw_pkg::PAGES))
                       && (tgt_mask != 8'd0);
         end
         fblw_pkg::K_READ: begin
            tgt_page = cur_y_ff;
            tgt_ok   = col_ok && ({1'b0, cur_y_ff} < 9'(fblw_pkg::PAGES));
         end
         default: begin
         end
      endcase
      tgt_lin  = 16'(tgt_page) * 16'(fblw_pkg::COLUMNS) + 16'(cur_x_ff);
      tgt_addr = tgt_lin[AW-1:0];
   end

   always_comb begin
      x_step     = ux_neg_ff ? cur_x_ff - 8'd1 : cur_x_ff + 8'd1;
      y_step     = uy_neg_ff ? cur_y_ff - 8'd1 : cur_y_ff + 8'd1;
      step_minor = (kind_ff == fblw_pkg::K_DIAGX) ? dy_ff : dx_ff;
      step_major = (kind_ff == fblw_pkg::K_DIAGX) ? dx_ff : dy_ff;
      eps_add    = eps_ff + $signed({3'd0, step_minor});
      eps_dbl    = {eps_add, 1'b0};
      take       = (eps_dbl >= $signed({4'd0, step_major}));
      fld_len    = (req_bit_count > 4'(fblw_pkg::MAX_BITS)) ?
                   4'(fblw_pkg::MAX_BITS) : req_bit_count;
      fld_bits   = 8'((9'd1 << fld_len) - 9'd1);
   end

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      end_x_in     = end_x_ff;
      end_y_in     = end_y_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      ux_neg_in    = ux_neg_ff;
      uy_neg_in    = uy_neg_ff;
      eps_in       = eps_ff;
      wdata_in     = wdata_ff;
      wmask_in     = wmask_ff;
      phase_in     = phase_ff;
      clr_cnt_in   = clr_cnt_ff;
      clr_rsp_in   = clr_rsp_ff;
      addr_in      = addr_ff;
      data_in      = data_ff;
      mask_in      = mask_ff;
      wen_in       = wen_ff;
      rd_ok_in     = rd_ok_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = 8'd0;
      mem_we       = 1'b0;
      mem_waddr    = addr_ff;
      mem_wdata    = (mem_q_ff & ~mask_ff) | (data_ff & mask_ff);

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cur_x_in = req_x_coord;
               cur_y_in = req_y_coord;
               case (req_action)
                  fblw_pkg::ACT_CLEAR: begin
                     state_in   = S_CLR;
                     clr_cnt_in = '0;
                     clr_rsp_in = 1'b1;
                  end
                  fblw_pkg::ACT_PIXEL: begin
                     kind_in  = fblw_pkg::K_PLOT;
                     state_in = S_RD;
                  end
                  fblw_pkg::ACT_LINE: begin
                     state_in  = S_RD;
                     end_x_in  = req_x_end;
                     end_y_in  = req_y_end;
                     ux_neg_in = (req_x_end < req_x_coord);
                     uy_neg_in = (req_y_end < req_y_coord);
                     dx_in     = ux_neg_in ? req_x_coord - req_x_end
                                           : req_x_end - req_x_coord;
                     dy_in     = uy_neg_in ? req_y_coord - req_y_end
                                           : req_y_end - req_y_coord;
                     eps_in    = '0;
                     if (req_x_coord == req_x_end) begin
                        kind_in  = fblw_pkg::K_VERT;
                        cur_y_in = uy_neg_in ? req_y_end : req_y_coord;
                        end_y_in = uy_neg_in ? req_y_coord : req_y_end;
                     end else if (req_y_coord == req_y_end) begin
                        kind_in  = fblw_pkg::K_HORZ;
                        cur_x_in = ux_neg_in ? req_x_end : req_x_coord;
                        end_x_in = ux_neg_in ? req_x_coord : req_x_end;
                     end else begin
                        kind_in = (dx_in > dy_in) ? fblw_pkg::K_DIAGX
                                                  : fblw_pkg::K_DIAGY;
                     end
                  end
                  fblw_pkg::ACT_FIELD: begin
                     kind_in  = fblw_pkg::K_FIELD;
                     state_in = S_RD;
                     phase_in = 1'b0;
                     wdata_in = 16'(req_bits_value & fld_bits) << req_y_coord[2:0];
                     wmask_in = 16'(fld_bits) << req_y_coord[2:0];
                  end
                  fblw_pkg::ACT_READ: begin
                     kind_in  = fblw_pkg::K_READ;
                     state_in = S_RDB;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_CLR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_cnt_ff;
            mem_wdata  = 8'd0;
            clr_cnt_in = clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == AW'(fblw_pkg::STORE_SIZE - 1)) begin
               state_in     = S_IDLE;
               rsp_valid_in = clr_rsp_ff;
            end
         end
         S_RD: begin
            addr_in  = tgt_addr;
            data_in  = tgt_data;
            mask_in  = tgt_mask;
            wen_in   = tgt_ok;
            state_in = S_WR;
         end
         S_WR: begin
            mem_we   = wen_ff;
            state_in = S_RD;
            case (kind_ff)
               fblw_pkg::K_VERT: begin
                  if (cur_y_ff == end_y_ff) begin
                     state_in = S_IDLE;
                  end else begin
                     cur_y_in = cur_y_ff + 8'd1;
                  end
               end
               fblw_pkg::K_HORZ: begin
                  if (cur_x_ff == end_x_ff) begin
                     state_in = S_IDLE;
                  end else begin
                     cur_x_in = cur_x_ff + 8'd1;
                  end
               end
               fblw_pkg::K_DIAGX: begin
                  cur_x_in = x_step;
                  eps_in   = take ? eps_add - $signed({3'd0, step_major}) : eps_add;
                  if (take) begin
                     cur_y_in = y_step;
                  end
                  if (x_step == end_x_ff) begin
                     state_in = S_IDLE;
                  end
               end
               fblw_pkg::K_DIAGY: begin
                  cur_y_in = y_step;
                  eps_in   = take ? eps_add - $signed({3'd0, step_major}) : eps_add;
                  if (take) begin
                     cur_x_in = x_step;
                  end
                  if (y_step == end_y_ff) begin
                     state_in = S_IDLE;
                  end
               end
               fblw_pkg::K_FIELD: begin
                  if (phase_ff) begin
                     state_in = S_IDLE;
                  end else begin
                     phase_in = 1'b1;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
            rsp_valid_in = (state_in == S_IDLE);
         end
         S_RDB: begin
            rd_ok_in = tgt_ok;
            state_in = S_RDO;
         end
         S_RDO: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            rsp_data_in  = rd_ok_ff ? mem_q_ff : 8'd0;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_q_ff <= mem[tgt_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_cnt_ff   <= '0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      end_x_ff    <= end_x_in;
      end_y_ff    <= end_y_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      ux_neg_ff   <= ux_neg_in;
      uy_neg_ff   <= uy_neg_in;
      eps_ff      <= eps_in;
      wdata_ff    <= wdata_in;
      wmask_ff    <= wmask_in;
      phase_ff    <= phase_in;
      addr_ff     <= addr_in;
      data_ff     <= data_in;
      mask_ff     <= mask_in;
      wen_ff      <= wen_in;
      rd_ok_ff    <= rd_ok_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == S_IDLE))
      else $error("Response strobe while a request is still running.");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid_ff))
      else $error("Accepted request neither ran nor responded.");

   a_data_only_on_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(state_ff == S_RDO)) |-> (rsp_data_ff == 8'd0))
      else $error("Nonzero response data for a request other than read.");

   a_clear_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLR && clr_cnt_ff != AW'(fblw_pkg::STORE_SIZE - 1)) |=>
      (state_ff == S_CLR && clr_cnt_ff == $past(clr_cnt_ff) + AW'(1)))
      else $error("Clearing pass skipped or left early.");

endmodule
